>>> sv/lsfb_pkg.sv
// Shared constants, codes and types for the LED strip frame builder.
package lsfb_pkg;

  localparam int unsigned LED_COUNT_DEF = 64;
  localparam int unsigned MAP_DEPTH     = 64;
  localparam int unsigned MAP_AW        = 6;

  localparam logic [31:0] LED_RESET_WORD = 32'hE100_0000;
  localparam logic [7:0]  NOT_DRIVEN     = 8'hFF;
  localparam logic [31:0] START_HALF     = 32'h0000_0000;
  localparam logic [31:0] END_HALF       = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_MAP  = 2'd1,
    OP_SEND = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SET,
    S_SEND
  } state_t;

  typedef struct packed {
    logic              we;
    logic [MAP_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [MAP_AW-1:0] raddr;
  } map_req_t;

endpackage

>>> sv/lsfb_in_if.sv
// Request channel carrying one LED strip operation.
interface lsfb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [5:0] position;
  logic [7:0] map_target;
  logic [7:0] brightness;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (
    output valid, operation, position, map_target, brightness, red, green, blue,
    input  ready
  );

  modport sink (
    input  valid, operation, position, map_target, brightness, red, green, blue,
    output ready
  );
endinterface

>>> sv/lsfb_out_if.sv
// Result channel carrying 64-bit frame words.
interface lsfb_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] frame_word;
  logic        last_word;

  modport source (
    output valid, frame_word, last_word,
    input  ready
  );

  modport sink (
    input  valid, frame_word, last_word,
    output ready
  );
endinterface

>>> sv/lsfb_mem.sv
// Frame store and position map memories, one write and one registered read port each.
module lsfb_mem #(
  parameter int unsigned LED_COUNT = lsfb_pkg::LED_COUNT_DEF
) (
  input  logic                                 clk,
  input  logic                                 led_we,
  input  logic [$clog2(LED_COUNT)-1:0]         led_waddr,
  input  logic [31:0]                          led_wdata,
  input  logic                                 led_re,
  input  logic [$clog2(LED_COUNT)-1:0]         led_raddr,
  output logic [31:0]                          led_rdata,
  input  lsfb_pkg::map_req_t                   map_req,
  output logic [7:0]                           map_rdata
);

  logic [31:0] led_mem [LED_COUNT];
  logic [7:0]  map_mem [lsfb_pkg::MAP_DEPTH];
  logic [31:0] led_rdata_r;
  logic [7:0]  map_rdata_r;

  always_ff @(posedge clk) begin
    if (led_we) begin
      led_mem[led_waddr] <= led_wdata;
    end
    if (led_re) begin
      led_rdata_r <= led_mem[led_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (map_req.we) begin
      map_mem[map_req.waddr] <= map_req.wdata;
    end
    if (map_req.re) begin
      map_rdata_r <= map_mem[map_req.raddr];
    end
  end

  assign led_rdata = led_rdata_r;
  assign map_rdata = map_rdata_r;

endmodule

>>> sv/lsfb_ctrl.sv
// Sequencer: memory clearing pass, set and map requests, and frame streaming.
module lsfb_ctrl #(
  parameter int unsigned LED_COUNT = lsfb_pkg::LED_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  lsfb_in_if.sink                      in_ch,
  lsfb_out_if.source                   out_ch,
  output logic                         led_we,
  output logic [$clog2(LED_COUNT)-1:0] led_waddr,
  output logic [31:0]                  led_wdata,
  output logic                         led_re,
  output logic [$clog2(LED_COUNT)-1:0] led_raddr,
  input  logic [31:0]                  led_rdata,
  output lsfb_pkg::map_req_t           map_req,
  input  logic [7:0]                   map_rdata
);

  localparam int unsigned IDX_W   = $clog2(LED_COUNT);
  localparam int unsigned WORDS   = (4 * LED_COUNT + 15) / 8;
  localparam int unsigned HALVES  = 2 * WORDS;
  localparam int unsigned HW      = $clog2(HALVES);
  localparam int unsigned CLR_LEN = (LED_COUNT > lsfb_pkg::MAP_DEPTH) ?
                                    LED_COUNT : lsfb_pkg::MAP_DEPTH;
  localparam int unsigned CW      = $clog2(CLR_LEN);

  localparam logic [HW-1:0] H_LED_LAST = HW'(LED_COUNT);
  localparam logic [HW-1:0] H_END      = HW'(LED_COUNT + 1);
  localparam logic [HW-1:0] H_FINAL    = HW'(HALVES - 1);
  localparam logic [CW-1:0] C_FINAL    = CW'(CLR_LEN - 1);

  lsfb_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    clr_r, clr_nxt;
  logic [HW-1:0]    h_r, h_nxt;
  logic [31:0]      hi_r, hi_nxt;
  logic [31:0]      set_word_r, set_word_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [63:0]      out_word_r, out_word_nxt;
  logic             out_last_r, out_last_nxt;
  logic             load_out;
  logic             advance;
  logic             slot_ok;
  logic [31:0]      half_val;

  // The frame is a run of 32-bit halves: a zero start half, one half per LED,
  // the all-ones end half, then zero padding when the LED count is odd.
  always_comb begin
    if (h_r == '0) begin
      half_val = lsfb_pkg::START_HALF;
    end else if (h_r <= H_LED_LAST) begin
      half_val = led_rdata;
    end else if (h_r == H_END) begin
      half_val = lsfb_pkg::END_HALF;
    end else begin
      half_val = lsfb_pkg::START_HALF;
    end
  end

  assign slot_ok = (map_rdata != lsfb_pkg::NOT_DRIVEN) && (32'(map_rdata) < LED_COUNT);
  assign advance = !h_r[0] || !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    h_nxt        = h_r;
    hi_nxt       = hi_r;
    set_word_nxt = set_word_r;
    out_word_nxt = out_word_r;
    out_last_nxt = out_last_r;
    load_out     = 1'b0;
    in_ch.ready  = 1'b0;
    led_we       = 1'b0;
    led_waddr    = '0;
    led_wdata    = set_word_r;
    led_re       = 1'b0;
    led_raddr    = h_r[IDX_W-1:0];
    map_req      = '0;

    case (state_r)
      lsfb_pkg::S_CLEAR: begin
        led_we        = 32'(clr_r) < LED_COUNT;
        led_waddr     = clr_r[IDX_W-1:0];
        led_wdata     = lsfb_pkg::LED_RESET_WORD;
        map_req.we    = 32'(clr_r) < lsfb_pkg::MAP_DEPTH;
        map_req.waddr = clr_r[lsfb_pkg::MAP_AW-1:0];
        map_req.wdata = 8'(clr_r[lsfb_pkg::MAP_AW-1:0]);
        if (clr_r == C_FINAL) begin
          state_nxt = lsfb_pkg::S_IDLE;
        end else begin
          clr_nxt = clr_r + CW'(1);
        end
      end
      lsfb_pkg::S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          set_word_nxt = {in_ch.brightness, in_ch.blue, in_ch.green, in_ch.red};
          case (in_ch.operation)
            lsfb_pkg::OP_SET: begin
              map_req.re    = 1'b1;
              map_req.raddr = in_ch.position;
              state_nxt     = lsfb_pkg::S_SET;
            end
            lsfb_pkg::OP_MAP: begin
              map_req.we    = 1'b1;
              map_req.waddr = in_ch.position;
              map_req.wdata = in_ch.map_target;
            end
            lsfb_pkg::OP_SEND: begin
              h_nxt     = '0;
              state_nxt = lsfb_pkg::S_SEND;
            end
            default: begin
            end
          endcase
        end
      end
      lsfb_pkg::S_SET: begin
        // The map entry read at accept time is now on the read port.
        led_we    = slot_ok;
        led_waddr = IDX_W'(map_rdata);
        state_nxt = lsfb_pkg::S_IDLE;
      end
      lsfb_pkg::S_SEND: begin
        if (advance) begin
          // Fetch ahead the LED word needed by the next half.
          led_re = 32'(h_r) < LED_COUNT;
          if (!h_r[0]) begin
            hi_nxt = half_val;
          end else begin
            load_out     = 1'b1;
            out_word_nxt = {hi_r, half_val};
            out_last_nxt = (h_r == H_FINAL);
          end
          if (h_r == H_FINAL) begin
            state_nxt = lsfb_pkg::S_IDLE;
          end else begin
            h_nxt = h_r + HW'(1);
          end
        end
      end
      default: begin
        state_nxt = lsfb_pkg::S_IDLE;
      end
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lsfb_pkg::S_CLEAR;
      clr_r       <= '0;
      h_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      h_r         <= h_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r       <= hi_nxt;
    set_word_r <= set_word_nxt;
    out_word_r <= out_word_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.frame_word = out_word_r;
  assign out_ch.last_word  = out_last_r;

  a_led_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    led_we |-> (32'(led_waddr) < LED_COUNT))
    else $error("frame store written beyond the last LED");

  a_send_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lsfb_pkg::S_SEND) |-> (!led_we && !map_req.we))
    else $error("memory written while a frame is streaming");

  a_last_ends_send: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && out_last_nxt) |=> (state_r == lsfb_pkg::S_IDLE))
    else $error("final frame word loaded without ending the send");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lsfb_pkg::S_CLEAR) |-> (!out_valid_r && !in_ch.ready))
    else $error("channel activity during the clearing pass");

endmodule

>>> sv/led_strip_frame_builder.sv
// LED strip frame builder: serial LED frame store with position remapping.
//
// in_ch takes requests: set colour (remapped through the position map), load a
// position map entry, or send the frame. out_ch returns 64-bit frame words,
// first transmitted byte in bits 63..56, with last_word on the final one.
// A map load is a single map write; a set is a map read, then a store write.
// A send streams (4*LED_COUNT+15)/8 words, 33 for 64 LEDs, each built from
// two 32-bit halves, since the single read port of the frame store gives one
// 32-bit LED word per cycle while the receiver does not stall the stream.
// in_ch.ready is low while a set or a send is in progress.
// After reset a clearing pass over max(LED_COUNT, 64) entries loads every LED
// word with 0xE1000000 and the position map with identity; in_ch.ready stays
// low during it. A result waits in the output register while the receiver
// stalls; streaming pauses on the next word until it is taken, and set and
// map requests are still accepted while the last word of a frame waits.
module led_strip_frame_builder #(
  parameter int unsigned LED_COUNT = lsfb_pkg::LED_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  lsfb_in_if.sink    in_ch,
  lsfb_out_if.source out_ch
);

  localparam int unsigned IDX_W = $clog2(LED_COUNT);

  logic               led_we;
  logic [IDX_W-1:0]   led_waddr;
  logic [31:0]        led_wdata;
  logic               led_re;
  logic [IDX_W-1:0]   led_raddr;
  logic [31:0]        led_rdata;
  lsfb_pkg::map_req_t map_req;
  logic [7:0]         map_rdata;

  lsfb_ctrl #(
    .LED_COUNT (LED_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .led_we    (led_we),
    .led_waddr (led_waddr),
    .led_wdata (led_wdata),
    .led_re    (led_re),
    .led_raddr (led_raddr),
    .led_rdata (led_rdata),
    .map_req   (map_req),
    .map_rdata (map_rdata)
  );

  lsfb_mem #(
    .LED_COUNT (LED_COUNT)
  ) u_mem (
    .clk       (clk),
    .led_we    (led_we),
    .led_waddr (led_waddr),
    .led_wdata (led_wdata),
    .led_re    (led_re),
    .led_raddr (led_raddr),
    .led_rdata (led_rdata),
    .map_req   (map_req),
    .map_rdata (map_rdata)
  );

endmodule
